@@ src/mekh_pkg.sv @@
`default_nettype none

package mekh_pkg;

   localparam int unsigned WORD_BITS = 32;
   localparam int unsigned ID_COUNT  = 8;

   typedef logic [WORD_BITS-1:0]               word_type;
   typedef logic [ID_COUNT-1:0][WORD_BITS-1:0] ids_type;

   typedef enum logic [1:0] {
      SHAPE_EDGE = 2'd0,
      SHAPE_TRI  = 2'd1,
      SHAPE_QUAD = 2'd2,
      SHAPE_HEX  = 2'd3
   } shape_type;

   // One request as it travels from the front end to the hash pipeline.
   typedef struct packed {
      shape_type shape;
      ids_type   ids;
   } item_type;

   typedef struct packed {
      logic     valid;
      item_type item;
   } q_push_type;

   typedef struct packed {
      word_type a;
      word_type b;
      word_type c;
   } abc_type;

   // Back-end stage plan: mix, first add, second mix, second add, final.
   localparam int unsigned MIX_LINES   = 6;
   localparam int unsigned FINAL_LINES = 7;
   localparam int unsigned ADD1_STAGE  = MIX_LINES;
   localparam int unsigned MIX2_FIRST  = ADD1_STAGE + 1;
   localparam int unsigned ADD2_STAGE  = MIX2_FIRST + MIX_LINES;
   localparam int unsigned FINAL_FIRST = ADD2_STAGE + 1;
   localparam int unsigned BACK_STAGES = FINAL_FIRST + FINAL_LINES;

   localparam int unsigned MIX_ROT   [MIX_LINES]   = '{4, 6, 8, 16, 19, 4};
   localparam int unsigned FINAL_ROT [FINAL_LINES] = '{14, 11, 25, 16, 4, 14, 24};

   function automatic word_type rotl(input word_type x, input int unsigned k);
      return (x << k) | (x >> (WORD_BITS - k));
   endfunction

   // One line of the mix round: one subtract, xor with a rotation, one add.
   function automatic abc_type mix_line(input abc_type s, input int unsigned k);
      abc_type r;
      r = s;
      case (k % 3)
         0: begin
            r.a = (s.a - s.c) ^ rotl(s.c, MIX_ROT[k]);
            r.c = s.c + s.b;
         end
         1: begin
            r.b = (s.b - s.a) ^ rotl(s.a, MIX_ROT[k]);
            r.a = s.a + s.c;
         end
         default: begin
            r.c = (s.c - s.b) ^ rotl(s.b, MIX_ROT[k]);
            r.b = s.b + s.a;
         end
      endcase
      return r;
   endfunction

   // One line of the final round: xor, then subtract a rotation.
   function automatic abc_type final_line(input abc_type s, input int unsigned k);
      abc_type r;
      r = s;
      case (k % 3)
         0: r.c = (s.c ^ s.b) - rotl(s.b, FINAL_ROT[k]);
         1: r.a = (s.a ^ s.c) - rotl(s.c, FINAL_ROT[k]);
         default: r.b = (s.b ^ s.a) - rotl(s.a, FINAL_ROT[k]);
      endcase
      return r;
   endfunction

endpackage

`default_nettype wire

@@ src/mesh_entity_key_hash.sv @@
`default_nettype none

// Order-independent 32-bit key for a mesh edge, triangle, quad or hexahedron.
// A request carries a shape code on req_cmd and up to eight vertex ids on
// req_id_0 .. req_id_7; ids that the shape does not use are ignored. The
// request is taken at a rising clock edge where start is high and busy is low.
// The front end pads and sorts the ids through eight registered compare
// layers and hands the sorted request to a small queue. The back end draws one
// request per cycle from the queue into a 21-stage pipeline: six mix lines, an
// add step, six more mix lines and a second add step (hexahedron only), and
// seven final lines, one line per stage.
// The key appears on rsp_key with rsp_strobe high for one cycle and is taken
// at the edge that ends that cycle. One request is accepted per cycle while
// busy is low, with results in request order. The receiver cannot stall, so
// the queue never fills in practice and busy stays low; it would rise only
// if the queue were full with a request waiting at the end of the sorter.
// Synchronous reset drops all requests in flight.
module mesh_entity_key_hash
   import mekh_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = 4
)
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   output logic                    busy,
   input  wire logic [1:0]         req_cmd,
   input  wire logic [31:0]        req_id_0,
   input  wire logic [31:0]        req_id_1,
   input  wire logic [31:0]        req_id_2,
   input  wire logic [31:0]        req_id_3,
   input  wire logic [31:0]        req_id_4,
   input  wire logic [31:0]        req_id_5,
   input  wire logic [31:0]        req_id_6,
   input  wire logic [31:0]        req_id_7,
   output logic                    rsp_strobe,
   output logic [31:0]             rsp_key
);

   item_type     req_item;
   q_push_type   push;
   logic         full;
   logic         q_valid;
   item_type     q_item;

   assign req_item.shape  = shape_type'(req_cmd);
   assign req_item.ids[0] = req_id_0;
   assign req_item.ids[1] = req_id_1;
   assign req_item.ids[2] = req_id_2;
   assign req_item.ids[3] = req_id_3;
   assign req_item.ids[4] = req_id_4;
   assign req_item.ids[5] = req_id_5;
   assign req_item.ids[6] = req_id_6;
   assign req_item.ids[7] = req_id_7;

   mekh_front u_front (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_item (req_item),
      .full     (full),
      .busy     (busy),
      .push     (push)
   );

   mekh_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .out_valid (q_valid),
      .out_item  (q_item)
   );

   mekh_back u_back (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (q_valid),
      .in_item    (q_item),
      .rsp_strobe (rsp_strobe),
      .rsp_key    (rsp_key)
   );

endmodule

`default_nettype wire

@@ src/mekh_front.sv @@
`default_nettype none

module mekh_front
   import mekh_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   input  wire item_type   req_item,
   input  wire logic       full,
   output logic            busy,
   output q_push_type      push
);

   localparam int unsigned SORT_LAYERS = ID_COUNT;
   localparam int unsigned COUNT_W     = $clog2(ID_COUNT + 1);

   item_type               st_ff [SORT_LAYERS+1];
   item_type               st_in [SORT_LAYERS+1];
   logic [SORT_LAYERS:0]   vld_ff;
   logic [SORT_LAYERS:0]   vld_in;
   logic                   advance;
   logic                   accept;
   logic [COUNT_W-1:0]     used;
   item_type               padded;

   // One layer of an odd-even transposition sort over disjoint neighbor pairs.
   function automatic item_type sort_layer(input item_type s, input logic odd);
      item_type r;
      r = s;
      for (int i = 0; i < ID_COUNT - 1; i++) begin
         if (1'(i) == odd && s.ids[i] > s.ids[i+1]) begin
            r.ids[i]   = s.ids[i+1];
            r.ids[i+1] = s.ids[i];
         end
      end
      return r;
   endfunction

   assign advance = !(full && vld_ff[SORT_LAYERS]);
   assign busy    = !advance;
   assign accept  = start && advance;

   // Unused slots are padded with the largest word so they sort to the top.
   always_comb begin
      case (req_item.shape)
         SHAPE_EDGE: used = COUNT_W'(2);
         SHAPE_TRI:  used = COUNT_W'(3);
         SHAPE_QUAD: used = COUNT_W'(4);
         default:    used = COUNT_W'(ID_COUNT);
      endcase
      padded.shape = req_item.shape;
      for (int i = 0; i < ID_COUNT; i++) begin
         padded.ids[i] = (COUNT_W'(i) < used) ? req_item.ids[i] : '1;
      end
   end

   always_comb begin
      if (advance) begin
         st_in[0]  = padded;
         vld_in[0] = accept;
      end else begin
         st_in[0]  = st_ff[0];
         vld_in[0] = vld_ff[0];
      end
      for (int k = 1; k <= SORT_LAYERS; k++) begin
         if (advance) begin
            st_in[k]  = sort_layer(st_ff[k-1], 1'(k - 1));
            vld_in[k] = vld_ff[k-1];
         end else begin
            st_in[k]  = st_ff[k];
            vld_in[k] = vld_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k <= SORT_LAYERS; k++) begin
         st_ff[k] <= st_in[k];
      end
   end

   assign push.valid = vld_ff[SORT_LAYERS] && !full;
   assign push.item  = st_ff[SORT_LAYERS];

endmodule

`default_nettype wire

@@ src/mekh_queue.sv @@
`default_nettype none

module mekh_queue
   import mekh_pkg::*;
#(
   parameter int unsigned DEPTH = 4
)
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire q_push_type  push,
   output logic             full,
   output logic             out_valid,
   output item_type         out_item
);

   localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);

   item_type           mem [DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff;
   logic [PTR_W-1:0]   wr_ptr_in;
   logic [PTR_W-1:0]   rd_ptr_ff;
   logic [PTR_W-1:0]   rd_ptr_in;
   logic [CNT_W-1:0]   count_ff;
   logic [CNT_W-1:0]   count_in;
   logic               pop;

   // The hash pipeline never stalls, so the head leaves as soon as it is there.
   assign out_valid = (count_ff != '0);
   assign pop       = out_valid;
   assign full      = (count_ff == CNT_W'(DEPTH));
   assign out_item  = mem[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push.valid) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push.valid && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push.valid) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push.valid) begin
         mem[wr_ptr_ff] <= push.item;
      end
   end

endmodule

`default_nettype wire

@@ src/mekh_back.sv @@
`default_nettype none

module mekh_back
   import mekh_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       in_valid,
   input  wire item_type   in_item,
   output logic            rsp_strobe,
   output word_type        rsp_key
);

   typedef struct packed {
      shape_type shape;
      abc_type   abc;
      ids_type   ids;
   } bk_type;

   bk_type                   entry;
   bk_type                   bk_ff [BACK_STAGES];
   bk_type                   bk_in [BACK_STAGES];
   logic [BACK_STAGES-1:0]   bk_vld_ff;

   // Each stage does one line of a round, or one add step, or passes through.
   function automatic bk_type stage_op(input bk_type x, input int unsigned s);
      bk_type r;
      r = x;
      if (s < ADD1_STAGE) begin
         r.abc = mix_line(x.abc, s);
      end else if (s == ADD1_STAGE) begin
         if (x.shape == SHAPE_QUAD || x.shape == SHAPE_HEX) begin
            r.abc.a = x.abc.a + x.ids[3];
         end
         if (x.shape == SHAPE_HEX) begin
            r.abc.b = x.abc.b + x.ids[4];
            r.abc.c = x.abc.c + x.ids[5];
         end
      end else if (s < ADD2_STAGE) begin
         if (x.shape == SHAPE_HEX) begin
            r.abc = mix_line(x.abc, s - MIX2_FIRST);
         end
      end else if (s == ADD2_STAGE) begin
         if (x.shape == SHAPE_HEX) begin
            r.abc.a = x.abc.a + x.ids[6];
            r.abc.b = x.abc.b + x.ids[7];
         end
      end else begin
         r.abc = final_line(x.abc, s - FINAL_FIRST);
      end
      return r;
   endfunction

   // The sorted ids are ascending; an edge takes the larger id as its first word.
   always_comb begin
      entry.shape = in_item.shape;
      entry.ids   = in_item.ids;
      if (in_item.shape == SHAPE_EDGE) begin
         entry.abc.a = in_item.ids[1];
         entry.abc.b = in_item.ids[0];
         entry.abc.c = '0;
      end else begin
         entry.abc.a = in_item.ids[0];
         entry.abc.b = in_item.ids[1];
         entry.abc.c = in_item.ids[2];
      end
   end

   for (genvar s = 0; s < BACK_STAGES; s++) begin : g_stage
      bk_type src;
      if (s == 0) begin : g_first
         assign src = entry;
      end else begin : g_next
         assign src = bk_ff[s-1];
      end
      assign bk_in[s] = stage_op(src, s);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bk_vld_ff <= '0;
      end else begin
         bk_vld_ff <= {bk_vld_ff[BACK_STAGES-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < BACK_STAGES; s++) begin
         bk_ff[s] <= bk_in[s];
      end
   end

   assign rsp_strobe = bk_vld_ff[BACK_STAGES-1];
   assign rsp_key    = bk_ff[BACK_STAGES-1].abc.c;

endmodule

`default_nettype wire

@@ src/mekh_checker.sv @@
`default_nettype none

module mekh_checker (
   input wire logic          clock,
   input wire logic          reset,
   input wire logic          start,
   input wire logic          busy,
   input wire logic          rsp_strobe,
   input wire logic [31:0]   rsp_key
);

   localparam int unsigned LATENCY = 31;

   logic accept;
   assign accept = start && !busy;

   // Reset empties the pipeline, so no result follows a reset cycle.
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_strobe)
      else $error("result strobe right after reset");

   // Every accepted request yields its key after the fixed pipeline latency.
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##LATENCY rsp_strobe)
      else $error("accepted request produced no result on time");

   // No result appears without a request accepted the same distance back.
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept, LATENCY))
      else $error("result without matching request");

   // The hash pipeline drains one request per cycle, so the queue never backs up.
   a_never_busy: assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy raised although the back end never stalls");

   // A key is never unknown while it is being delivered.
   a_key_known: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !$isunknown(rsp_key))
      else $error("unknown key delivered");

endmodule

bind mesh_entity_key_hash mekh_checker u_mekh_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp_key    (rsp_key)
);

`default_nettype wire

@@ sim/mesh_entity_key_hash_checker.sv @@
`timescale 1ns / 1ps

// Watches both channels of the key hash block. It predicts the key of every
// accepted request and compares each strobed key with the oldest prediction.
module mesh_entity_key_hash_checker
   import mekh_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   input  wire logic        busy,
   input  wire logic [1:0]  req_cmd,
   input  wire logic [31:0] req_id_0,
   input  wire logic [31:0] req_id_1,
   input  wire logic [31:0] req_id_2,
   input  wire logic [31:0] req_id_3,
   input  wire logic [31:0] req_id_4,
   input  wire logic [31:0] req_id_5,
   input  wire logic [31:0] req_id_6,
   input  wire logic [31:0] req_id_7,
   input  wire logic        rsp_strobe,
   input  wire logic [31:0] rsp_key,
   output int               fail_count,
   output int               pending_keys
);

   typedef struct packed {
      word_type a;
      word_type b;
      word_type c;
   } hash_words_type;

   typedef struct {
      shape_type shape;
      word_type  key;
   } key_entry_type;

   key_entry_type expected_keys[$];
   int            error_total = 0;

   function automatic word_type rot_left(input word_type x, input int k);
      return (x << k) | (x >> (32 - k));
   endfunction

   function automatic hash_words_type mix_round(input hash_words_type s);
      s.a = (s.a - s.c) ^ rot_left(s.c, 4);   s.c = s.c + s.b;
      s.b = (s.b - s.a) ^ rot_left(s.a, 6);   s.a = s.a + s.c;
      s.c = (s.c - s.b) ^ rot_left(s.b, 8);   s.b = s.b + s.a;
      s.a = (s.a - s.c) ^ rot_left(s.c, 16);  s.c = s.c + s.b;
      s.b = (s.b - s.a) ^ rot_left(s.a, 19);  s.a = s.a + s.c;
      s.c = (s.c - s.b) ^ rot_left(s.b, 4);   s.b = s.b + s.a;
      return s;
   endfunction

   function automatic hash_words_type final_round(input hash_words_type s);
      s.c = (s.c ^ s.b) - rot_left(s.b, 14);
      s.a = (s.a ^ s.c) - rot_left(s.c, 11);
      s.b = (s.b ^ s.a) - rot_left(s.a, 25);
      s.c = (s.c ^ s.b) - rot_left(s.b, 16);
      s.a = (s.a ^ s.c) - rot_left(s.c, 4);
      s.b = (s.b ^ s.a) - rot_left(s.a, 14);
      s.c = (s.c ^ s.b) - rot_left(s.b, 24);
      return s;
   endfunction

   // Sorts the ids that the shape uses, then runs the rounds for that shape.
   function automatic word_type entity_key(input shape_type shape, input ids_type ids);
      word_type       v [8];
      word_type       t;
      hash_words_type s;
      int             n;
      int             i;
      int             j;
      for (i = 0; i < 8; i++) v[i] = ids[i];
      case (shape)
         SHAPE_EDGE: n = 2;
         SHAPE_TRI:  n = 3;
         SHAPE_QUAD: n = 4;
         default:    n = 8;
      endcase
      for (i = 1; i < n; i++) begin
         t = v[i];
         j = i;
         while (j > 0 && v[j-1] > t) begin
            v[j] = v[j-1];
            j--;
         end
         v[j] = t;
      end
      if (shape == SHAPE_EDGE) begin
         s.a = v[1];
         s.b = v[0];
         s.c = '0;
      end else begin
         s.a = v[0];
         s.b = v[1];
         s.c = v[2];
      end
      s = mix_round(s);
      if (shape == SHAPE_QUAD) begin
         s.a = s.a + v[3];
      end else if (shape == SHAPE_HEX) begin
         s.a = s.a + v[3];
         s.b = s.b + v[4];
         s.c = s.c + v[5];
         s = mix_round(s);
         s.a = s.a + v[6];
         s.b = s.b + v[7];
      end
      s = final_round(s);
      return s.c;
   endfunction

   always @(posedge clock) begin : watch
      key_entry_type entry;
      ids_type       ids;
      if (reset) begin
         expected_keys.delete();
      end else begin
         if (rsp_strobe) begin
            if (expected_keys.size() == 0) begin
               if (error_total < 10)
                  $display("unexpected key %h with no request outstanding", rsp_key);
               error_total++;
            end else begin
               entry = expected_keys.pop_front();
               if (rsp_key !== entry.key) begin
                  if (error_total < 10)
                     $display("%s key mismatch: expected %h, got %h",
                              entry.shape.name(), entry.key, rsp_key);
                  error_total++;
               end
            end
         end
         if (start && !busy) begin
            ids = {req_id_7, req_id_6, req_id_5, req_id_4,
                   req_id_3, req_id_2, req_id_1, req_id_0};
            entry.shape = shape_type'(req_cmd);
            entry.key   = entity_key(entry.shape, ids);
            expected_keys.push_back(entry);
         end
      end
      fail_count   <= error_total;
      pending_keys <= expected_keys.size();
   end

endmodule

@@ sim/tb_mesh_entity_key_hash.sv @@
`timescale 1ns / 1ps

// Top of the key hash testbench. This module only produces requests and
// delivers the verdict; the checker beside the block predicts every key and
// counts failures.
module tb_mesh_entity_key_hash
   import mekh_pkg::*;
;

   // A correct run never goes this many cycles without a request or a key
   // changing hands: the pipeline and the longest random sender gap are both
   // far shorter.
   localparam int STALL_LIMIT  = 1000;
   // Cycles to keep watching after the last key, in case a stray key follows.
   localparam int DRAIN_CYCLES = 40;
   localparam word_type ALL_ONES = '1;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [1:0]  req_cmd;
   logic [31:0] req_id_0;
   logic [31:0] req_id_1;
   logic [31:0] req_id_2;
   logic [31:0] req_id_3;
   logic [31:0] req_id_4;
   logic [31:0] req_id_5;
   logic [31:0] req_id_6;
   logic [31:0] req_id_7;
   logic        rsp_strobe;
   logic [31:0] rsp_key;

   int fail_count;
   int pending_keys;
   int quiet_cycles = 0;

   mesh_entity_key_hash dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_cmd    (req_cmd),
      .req_id_0   (req_id_0),
      .req_id_1   (req_id_1),
      .req_id_2   (req_id_2),
      .req_id_3   (req_id_3),
      .req_id_4   (req_id_4),
      .req_id_5   (req_id_5),
      .req_id_6   (req_id_6),
      .req_id_7   (req_id_7),
      .rsp_strobe (rsp_strobe),
      .rsp_key    (rsp_key)
   );

   mesh_entity_key_hash_checker checker_0 (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .busy         (busy),
      .req_cmd      (req_cmd),
      .req_id_0     (req_id_0),
      .req_id_1     (req_id_1),
      .req_id_2     (req_id_2),
      .req_id_3     (req_id_3),
      .req_id_4     (req_id_4),
      .req_id_5     (req_id_5),
      .req_id_6     (req_id_6),
      .req_id_7     (req_id_7),
      .rsp_strobe   (rsp_strobe),
      .rsp_key      (rsp_key),
      .fail_count   (fail_count),
      .pending_keys (pending_keys)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // The watchdog counts cycles in which neither a request nor a key is
   // accepted. Any handshake clears the count.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin : watchdog
      while (quiet_cycles < STALL_LIMIT) @(posedge clock);
      $display("FAIL");
      $finish;
   end

   // Presents one request, starting at a falling edge, and holds it until a
   // rising edge sees busy low. It returns at the next falling edge with
   // start still high, so a back-to-back request just replaces the fields.
   task automatic send_request(input shape_type shape, input ids_type ids);
      bit accepted;
      req_cmd  = shape;
      req_id_0 = ids[0];
      req_id_1 = ids[1];
      req_id_2 = ids[2];
      req_id_3 = ids[3];
      req_id_4 = ids[4];
      req_id_5 = ids[5];
      req_id_6 = ids[6];
      req_id_7 = ids[7];
      start    = 1'b1;
      accepted = 1'b0;
      while (!accepted) begin
         @(posedge clock);
         accepted = !busy;
      end
      @(negedge clock);
   endtask

   task automatic send_ids(input shape_type shape,
                           input word_type w0, input word_type w1,
                           input word_type w2, input word_type w3,
                           input word_type w4, input word_type w5,
                           input word_type w6, input word_type w7);
      send_request(shape, {w7, w6, w5, w4, w3, w2, w1, w0});
   endtask

   // The sender stays idle cycle by cycle with the given chance, so gaps of
   // any length land on every stage of the pipeline. While idle, the fields
   // carry noise that the block must ignore.
   task automatic idle_gap(input int idle_pct);
      while ($urandom_range(99) < idle_pct) begin
         start    = 1'b0;
         req_cmd  = 2'($urandom);
         req_id_0 = $urandom;
         req_id_1 = $urandom;
         req_id_2 = $urandom;
         req_id_3 = $urandom;
         req_id_4 = $urandom;
         req_id_5 = $urandom;
         req_id_6 = $urandom;
         req_id_7 = $urandom;
         @(negedge clock);
      end
   endtask

   // Holds off new requests until every predicted key has come back.
   task automatic wait_for_drain();
      start = 1'b0;
      while (pending_keys != 0) @(negedge clock);
   endtask

   // Each id is either fully random, small (so duplicates are common), or one
   // of the corner values of the 32-bit range.
   function automatic ids_type random_ids();
      ids_type ids;
      for (int i = 0; i < 8; i++) begin
         case ($urandom_range(3))
            0, 1: ids[i] = $urandom;
            2:    ids[i] = $urandom_range(15);
            default: begin
               case ($urandom_range(5))
                  0:       ids[i] = 32'h0000_0000;
                  1:       ids[i] = 32'h0000_0001;
                  2:       ids[i] = 32'h7FFF_FFFF;
                  3:       ids[i] = 32'h8000_0000;
                  4:       ids[i] = 32'hFFFF_FFFE;
                  default: ids[i] = ALL_ONES;
               endcase
            end
         endcase
      end
      return ids;
   endfunction

   // A stretch of random requests. Now and then the sender pauses until the
   // pipeline is empty, so a request also meets a fully idle block.
   task automatic run_phase(input int count, input int idle_pct);
      repeat (count) begin
         idle_gap(idle_pct);
         if ($urandom_range(99) < 2) wait_for_drain();
         send_request(shape_type'($urandom_range(3)), random_ids());
      end
   endtask

   initial begin : stimulus
      reset    = 1'b1;
      start    = 1'b0;
      req_cmd  = '0;
      req_id_0 = '0;
      req_id_1 = '0;
      req_id_2 = '0;
      req_id_3 = '0;
      req_id_4 = '0;
      req_id_5 = '0;
      req_id_6 = '0;
      req_id_7 = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Every shape with all ids zero and with all ids at the top of the
      // range; equal ids everywhere.
      send_ids(SHAPE_EDGE, 0, 0, 0, 0, 0, 0, 0, 0);
      send_ids(SHAPE_TRI,  0, 0, 0, 0, 0, 0, 0, 0);
      send_ids(SHAPE_QUAD, 0, 0, 0, 0, 0, 0, 0, 0);
      send_ids(SHAPE_HEX,  0, 0, 0, 0, 0, 0, 0, 0);
      send_ids(SHAPE_EDGE, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES,
               ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES);
      send_ids(SHAPE_TRI,  ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES,
               ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES);
      send_ids(SHAPE_QUAD, ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES,
               ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES);
      send_ids(SHAPE_HEX,  ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES,
               ALL_ONES, ALL_ONES, ALL_ONES, ALL_ONES);

      // Edges in both orders with noise in the unused ids; both orders of an edge
      // must give the same key.
      send_ids(SHAPE_EDGE, 5, 3, $urandom, $urandom, $urandom, $urandom,
               $urandom, $urandom);
      send_ids(SHAPE_EDGE, 3, 5, $urandom, $urandom, $urandom, $urandom,
               $urandom, $urandom);
      send_ids(SHAPE_EDGE, 0, ALL_ONES, $urandom, $urandom, $urandom,
               $urandom, $urandom, $urandom);
      send_ids(SHAPE_EDGE, ALL_ONES, 0, $urandom, $urandom, $urandom,
               $urandom, $urandom, $urandom);

      // Triangles: reversed order and a repeated id; unused ids are noise.
      send_ids(SHAPE_TRI, 3, 2, 1, $urandom, $urandom, $urandom, $urandom,
               $urandom);
      send_ids(SHAPE_TRI, 9, 1, 9, $urandom, $urandom, $urandom, $urandom,
               $urandom);

      // A quad that mixes the corner values, then the same set reordered.
      send_ids(SHAPE_QUAD, ALL_ONES, 0, 32'h8000_0000, 1, $urandom, $urandom,
               $urandom, $urandom);
      send_ids(SHAPE_QUAD, 1, 32'h8000_0000, 0, ALL_ONES, $urandom, $urandom,
               $urandom, $urandom);

      // Hexahedra: descending, ascending, pairs of duplicates, and corner values.
      send_ids(SHAPE_HEX, 8, 7, 6, 5, 4, 3, 2, 1);
      send_ids(SHAPE_HEX, 1, 2, 3, 4, 5, 6, 7, 8);
      send_ids(SHAPE_HEX, 2, 2, 0, 0, ALL_ONES, ALL_ONES, 5, 5);
      send_ids(SHAPE_HEX, ALL_ONES, 32'hFFFF_FFFE, 32'h8000_0000,
               32'h7FFF_FFFF, 1, 0, ALL_ONES, 0);
      wait_for_drain();

      // Random requests: back to back, a mostly idle sender, a lightly idle
      // sender, and back to back again.
      run_phase(150, 0);
      run_phase(150, 74);
      wait_for_drain();
      run_phase(150, 31);
      run_phase(100, 0);

      wait_for_drain();
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0 && pending_keys == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule

@@ files.f @@
src/mekh_pkg.sv
src/mekh_front.sv
src/mekh_queue.sv
src/mekh_back.sv
src/mesh_entity_key_hash.sv
src/mekh_checker.sv
sim/mesh_entity_key_hash_checker.sv
sim/tb_mesh_entity_key_hash.sv
